FILE: design/ltok_pkg.sv
`default_nettype none

package ltok_pkg;

  localparam int unsigned LINE_MAX_DEFAULT = 4096;
  localparam int unsigned WORD_CHARS       = 8;
  localparam int unsigned N_WORDS          = 36;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned KIND_W   = 6;
  localparam int unsigned VALUE_W  = 63;
  localparam int unsigned START_W  = 12;
  localparam int unsigned LENGTH_W = 13;

  localparam logic [KIND_W-1:0]  KIND_NUMBER    = 6'd0;
  localparam logic [KIND_W-1:0]  KIND_IDENT     = 6'd1;
  localparam logic [KIND_W-1:0]  KIND_WORD_BASE = 6'd2;
  localparam logic [VALUE_W-1:0] VALUE_MAX      = '1;

  typedef enum logic [2:0] {
    CL_LETTER  = 3'd0,
    CL_DIGIT   = 3'd1,
    CL_BRACKET = 3'd2,
    CL_SPACE   = 3'd3,
    CL_OPER    = 3'd4,
    CL_OTHER   = 3'd5
  } cls_e;

  typedef enum logic [3:0] {
    MODE_NONE   = 4'b0001,
    MODE_LETTER = 4'b0010,
    MODE_DIGIT  = 4'b0100,
    MODE_OPER   = 4'b1000
  } mode_e;

  typedef logic [WORD_CHARS-1:0][7:0] head_t;

  typedef struct packed {
    logic              eol;
    logic [7:0]        ch;
    cls_e              cls;
    logic [3:0]        digit;
    logic [KIND_W-1:0] bkind;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qslot_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic                last;
  } token_t;

  // Word texts are right aligned: the final character sits in the low byte.
  localparam logic [63:0] WORD_TXT [N_WORDS] = '{
    64'("+"), 64'("-"), 64'("*"), 64'("/"), 64'("%"), 64'("="), 64'("=="),
    64'("("), 64'(")"), 64'("["), 64'("]"), 64'("{"), 64'("}"),
    64'("||"), 64'("&&"), 64'("!"), 64'("|"), 64'("&"), 64'("~"), 64'("^"),
    64'(":"), 64'("."), 64'(";"), 64'(","),
    64'("return"), 64'("if"), 64'("else"), 64'("for"), 64'("while"), 64'("def"),
    64'("break"), 64'("continue"), 64'("func"), 64'("read"), 64'("print"),
    64'("var")
  };

  localparam logic [3:0] WORD_LEN [N_WORDS] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1,
    4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd3,
    4'd5, 4'd8, 4'd4, 4'd4, 4'd5, 4'd3
  };

  // Returns the word code of an exact match, or KIND_NUMBER when none matches.
  function automatic logic [KIND_W-1:0] match_word(head_t hd, logic [3:0] len);
    logic [KIND_W-1:0] kind;
    logic              hit;
    logic [2:0]        sel;
    kind = KIND_NUMBER;
    for (int w = N_WORDS - 1; w >= 0; w--) begin
      hit = (len == WORD_LEN[w]);
      for (int k = 0; k < WORD_CHARS; k++) begin
        sel = 3'(int'(WORD_LEN[w]) - 1 - k);
        if ((k < int'(WORD_LEN[w])) && (hd[k] != WORD_TXT[w][8*sel +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = KIND_WORD_BASE + KIND_W'(w);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

FILE: design/ltok_ifs.sv
`default_nettype none

interface ltok_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] ch;

  modport source (output valid, req_type, ch, input ready);
  modport sink (input valid, req_type, ch, output ready);
endinterface

interface ltok_tok_if import ltok_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   token_kind;
  logic [VALUE_W-1:0]  number_value;
  logic [START_W-1:0]  token_start;
  logic [LENGTH_W-1:0] token_length;
  logic                last;

  modport source (
    output valid, token_kind, number_value, token_start, token_length, last,
    input ready
  );
  modport sink (
    input valid, token_kind, number_value, token_start, token_length, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/ltok_front.sv
`default_nettype none

module ltok_front import ltok_pkg::*; (
  ltok_req_if.sink req_i,
  input  logic     full_i,
  output qslot_t   push_o
);

  function automatic cls_e class_of(logic [7:0] c);
    cls_e cls;
    priority if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      cls = CL_LETTER;
    end else if (c >= "0" && c <= "9") begin
      cls = CL_DIGIT;
    end else if (c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}") begin
      cls = CL_BRACKET;
    end else if (c == " ") begin
      cls = CL_SPACE;
    end else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "=" || c == "!" ||
                 c == "~" || c == ">" || c == "<" || c == "|" || c == "^" || c == "%" ||
                 c == "." || c == "," || c == "'" || c == "\"" || c == ";" || c == ":") begin
      cls = CL_OPER;
    end else begin
      cls = CL_OTHER;
    end
    return cls;
  endfunction

  cls_e  cls;
  head_t one_char;

  assign req_i.ready = !full_i;
  assign cls         = class_of(req_i.ch);

  always_comb begin
    one_char    = '0;
    one_char[0] = req_i.ch;

    push_o.valid       = req_i.valid && !full_i;
    push_o.entry.eol   = req_i.req_type;
    push_o.entry.ch    = req_i.ch;
    push_o.entry.cls   = cls;
    // ASCII digits carry their value in the low nibble.
    push_o.entry.digit = (cls == CL_DIGIT) ? req_i.ch[3:0] : 4'd0;
    push_o.entry.bkind = (cls == CL_BRACKET) ? match_word(one_char, 4'd1) : KIND_NUMBER;
  end

endmodule

`default_nettype wire

FILE: design/ltok_queue.sv
`default_nettype none

module ltok_queue import ltok_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  qslot_t push_i,
  output logic   full_o,
  output qslot_t head_o,
  input  logic   pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o       = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_d  = do_push ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

endmodule

`default_nettype wire

FILE: design/ltok_back.sv
`default_nettype none

module ltok_back import ltok_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qslot_t     q_i,
  output logic       pop_o,
  ltok_tok_if.source tok_o
);

  localparam int unsigned PW = $clog2(LINE_MAX + 1);
  localparam int unsigned SW = $clog2(LINE_MAX);
  localparam int unsigned PROD_W = VALUE_W + 4;

  entry_t e;

  mode_e              mode_q, mode_d;
  logic               line_head_q, line_head_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [SW-1:0]      start_q, start_d;
  head_t              hd_q, hd_d;
  logic [PW-1:0]      len_q, len_d;
  logic               only_dig_q, only_dig_d;
  logic [VALUE_W-1:0] acc_q, acc_d;

  logic               out_valid_q, out_valid_d;
  token_t             out_q, out_d;
  logic               br_pend_q, br_pend_d;
  token_t             br_q, br_d;

  logic               brk;
  logic               txt_v;
  logic               br_v;
  logic               do_app;
  logic               fresh;
  logic               in_line;
  logic [SW-1:0]      pos_s;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] app_acc;
  logic [3:0]         len_small;
  logic [KIND_W-1:0]  hit_kind;
  logic [31:0]        start_w;
  logic [31:0]        len_w;
  logic [31:0]        pos_w;
  token_t             txt_tok;
  token_t             br_tok;
  logic               needs_out;
  logic               out_free;
  logic               step;

  assign e       = q_i.entry;
  assign in_line = (pos_q < PW'(LINE_MAX));
  assign pos_s   = SW'(pos_q);

  // Saturating value * 10 + digit; any carry above the value width saturates.
  assign prod    = PROD_W'({acc_q, 3'b000}) + PROD_W'({acc_q, 1'b0}) + PROD_W'(e.digit);
  assign app_acc = (prod[PROD_W-1:VALUE_W] != '0) ? VALUE_MAX : prod[VALUE_W-1:0];

  always_comb begin
    unique case (mode_q)
      MODE_LETTER: brk = (e.cls == CL_OPER) || (e.cls == CL_BRACKET);
      MODE_DIGIT:  brk = (e.cls != CL_DIGIT);
      MODE_OPER:   brk = (e.cls != CL_OPER);
      default:     brk = 1'b0;
    endcase
  end

  // Run machine: next state and which tokens this entry produces.
  always_comb begin
    mode_d      = mode_q;
    line_head_d = line_head_q;
    pos_d       = pos_q;
    start_d     = start_q;
    hd_d        = hd_q;
    len_d       = len_q;
    only_dig_d  = only_dig_q;
    acc_d       = acc_q;
    txt_v       = 1'b0;
    br_v        = 1'b0;
    do_app      = 1'b0;
    fresh       = 1'b0;

    if (e.eol) begin
      txt_v       = (len_q != '0);
      mode_d      = MODE_NONE;
      line_head_d = 1'b1;
      pos_d       = '0;
      start_d     = '0;
      len_d       = '0;
      only_dig_d  = 1'b1;
      acc_d       = '0;
    end else if (in_line) begin
      pos_d = pos_q + PW'(1);
      if (line_head_q && (e.cls == CL_OTHER)) begin
        do_app = 1'b1;
      end else begin
        line_head_d = 1'b0;
        if (e.cls == CL_SPACE) begin
          if (len_q != '0) begin
            txt_v      = 1'b1;
            mode_d     = MODE_NONE;
            len_d      = '0;
            only_dig_d = 1'b1;
            acc_d      = '0;
          end else begin
            do_app = 1'b1;
          end
        end else if ((mode_q != MODE_NONE) && !brk) begin
          do_app = 1'b1;
        end else begin
          // A broken run is flushed, then the byte starts over from no run.
          txt_v = brk;
          unique case (e.cls)
            CL_LETTER: mode_d = MODE_LETTER;
            CL_DIGIT:  mode_d = MODE_DIGIT;
            CL_OPER:   mode_d = MODE_OPER;
            default:   mode_d = MODE_NONE;
          endcase
          if (e.cls == CL_BRACKET) begin
            br_v       = 1'b1;
            len_d      = '0;
            only_dig_d = 1'b1;
            acc_d      = '0;
          end else begin
            fresh = 1'b1;
          end
        end
      end
    end

    if (do_app) begin
      if (len_q == '0) begin
        start_d = pos_s;
      end
      if (len_q < PW'(WORD_CHARS)) begin
        hd_d[len_q[2:0]] = e.ch;
      end
      len_d = len_q + PW'(1);
      if (e.cls == CL_DIGIT) begin
        acc_d = app_acc;
      end else begin
        only_dig_d = 1'b0;
      end
    end

    if (fresh) begin
      start_d    = pos_s;
      hd_d[0]    = e.ch;
      len_d      = PW'(1);
      only_dig_d = (e.cls == CL_DIGIT);
      acc_d      = VALUE_W'(e.digit);
    end
  end

  // Token built from the pending text.
  always_comb begin
    len_small = (len_q <= PW'(WORD_CHARS)) ? 4'(len_q) : 4'hF;
    hit_kind  = match_word(hd_q, len_small);
    start_w   = 32'(start_q);
    len_w     = 32'(len_q);
    pos_w     = 32'(pos_q);

    txt_tok.start  = start_w[START_W-1:0];
    txt_tok.length = len_w[LENGTH_W-1:0];
    txt_tok.last   = !br_v;
    if (hit_kind != KIND_NUMBER) begin
      txt_tok.kind  = hit_kind;
      txt_tok.value = '0;
    end else if (only_dig_q) begin
      txt_tok.kind  = KIND_NUMBER;
      txt_tok.value = acc_q;
    end else begin
      txt_tok.kind  = KIND_IDENT;
      txt_tok.value = '0;
    end

    br_tok.kind   = e.bkind;
    br_tok.value  = '0;
    br_tok.start  = pos_w[START_W-1:0];
    br_tok.length = LENGTH_W'(1);
    br_tok.last   = 1'b1;
  end

  // An entry making no token moves on despite a stall unless a bracket waits.
  assign needs_out = txt_v || br_v;
  assign out_free  = !out_valid_q || tok_o.ready;
  assign step      = q_i.valid && !br_pend_q && (out_free || !needs_out);
  assign pop_o     = step;

  always_comb begin
    out_valid_d = out_valid_q && !tok_o.ready;
    out_d       = out_q;
    br_pend_d   = br_pend_q;
    br_d        = br_q;
    if (br_pend_q && out_free) begin
      out_valid_d = 1'b1;
      out_d       = br_q;
      br_pend_d   = 1'b0;
    end else if (step && needs_out) begin
      out_valid_d = 1'b1;
      out_d       = txt_v ? txt_tok : br_tok;
      if (txt_v && br_v) begin
        br_pend_d = 1'b1;
        br_d      = br_tok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NONE;
      line_head_q <= 1'b1;
      pos_q       <= '0;
      start_q     <= '0;
      len_q       <= '0;
      only_dig_q  <= 1'b1;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      br_pend_q   <= 1'b0;
    end else begin
      if (step) begin
        mode_q      <= mode_d;
        line_head_q <= line_head_d;
        pos_q       <= pos_d;
        start_q     <= start_d;
        len_q       <= len_d;
        only_dig_q  <= only_dig_d;
        acc_q       <= acc_d;
      end
      out_valid_q <= out_valid_d;
      br_pend_q   <= br_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      hd_q <= hd_d;
    end
    out_q <= out_d;
    br_q  <= br_d;
  end

  assign tok_o.valid        = out_valid_q;
  assign tok_o.token_kind   = out_q.kind;
  assign tok_o.number_value = out_q.value;
  assign tok_o.token_start  = out_q.start;
  assign tok_o.token_length = out_q.length;
  assign tok_o.last         = out_q.last;

endmodule

`default_nettype wire

FILE: design/line_tokenizer.sv
// Line tokenizer.
// req_i carries one transaction per byte of a line (req_type 0, byte in ch)
// or an end-of-line marker (req_type 1), which flushes pending text and
// returns the block to its start-of-line state.
// tok_o carries one transaction per token: kind, decimal value for numbers,
// start position, length, and last set on the final token of an input byte.
// A token passes through a queue entry and then the output register before
// it is shown on tok_o. Throughput: one input transaction per cycle while
// the queue is not full. A byte that both ends a run and is a bracket
// makes two tokens; the run machine takes no queue entry while the second
// one waits for the output register.
// A two-entry queue separates byte classification from the run machine, so
// input keeps flowing while a token waits; bytes that make no token pass
// through the run machine even while tok_o stalls, unless a bracket waits.
// Reset clears the queue, the output register and the run state; the block
// accepts input as soon as reset is released. Bytes beyond
// LINE_MAX positions in a line are dropped.
`default_nettype none

module line_tokenizer import ltok_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltok_req_if.sink   req_i,
  ltok_tok_if.source tok_o
);

  qslot_t push;
  qslot_t head;
  logic   full;
  logic   pop;

  ltok_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push)
  );

  ltok_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  ltok_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (head),
    .pop_o  (pop),
    .tok_o  (tok_o)
  );

endmodule

`default_nettype wire

FILE: design/ltok_checker.sv
`default_nettype none

module ltok_checker import ltok_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                tok_valid_i,
  input logic                tok_ready_i,
  input logic [KIND_W-1:0]   tok_kind_i,
  input logic [VALUE_W-1:0]  tok_value_i,
  input logic [START_W-1:0]  tok_start_i,
  input logic [LENGTH_W-1:0] tok_length_i,
  input logic                tok_last_i
);

  a_tok_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_ready_i |=> tok_valid_i && $stable(tok_kind_i) &&
      $stable(tok_value_i) && $stable(tok_start_i) && $stable(tok_length_i) &&
      $stable(tok_last_i))
    else $error("token transaction changed while stalled");

  // A run token that is not last is followed at once by the bracket that broke it.
  a_bracket_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_ready_i && !tok_last_i |=> tok_valid_i &&
      (tok_length_i == LENGTH_W'(1)) &&
      (tok_start_i == START_W'($past(tok_start_i) + $past(tok_length_i[START_W-1:0]))))
    else $error("second token of a byte missing or misplaced");

  a_value_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && (tok_value_i != '0) |-> tok_kind_i == KIND_NUMBER)
    else $error("nonzero value on a token that is not a number");

endmodule

bind line_tokenizer ltok_checker u_ltok_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tok_valid_i  (tok_o.valid),
  .tok_ready_i  (tok_o.ready),
  .tok_kind_i   (tok_o.token_kind),
  .tok_value_i  (tok_o.number_value),
  .tok_start_i  (tok_o.token_start),
  .tok_length_i (tok_o.token_length),
  .tok_last_i   (tok_o.last)
);

`default_nettype wire

FILE: verif/line_tokenizer_tb.sv
`default_nettype none

module line_tokenizer_tb;
  import ltok_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LINE_LIMIT   = LINE_MAX_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned CALM_FROM    = 300;
  localparam int unsigned CALM_TO      = 480;
  localparam int unsigned IDLE_PCT     = 37;

  localparam logic [VALUE_W:0] NUM_MAX = {1'b0, VALUE_MAX};

  localparam logic [KIND_W-1:0] KIND_LPAREN = KIND_WORD_BASE + 6'd7;
  localparam logic [KIND_W-1:0] KIND_ANDAND = KIND_WORD_BASE + 6'd14;
  localparam logic [KIND_W-1:0] KIND_IF     = KIND_WORD_BASE + 6'd25;

  // How a directed row is checked: by the tokenizer model, not at all, or by the typed value.
  localparam logic [1:0] CHK_MODEL = 2'd0;
  localparam logic [1:0] CHK_NONE  = 2'd1;
  localparam logic [1:0] CHK_ONE   = 2'd2;

  typedef struct packed {
    logic                eol;
    logic [7:0]          ch;
    logic [1:0]          chk;
    logic [KIND_W-1:0]   kind;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
  } probe_row_t;

  typedef struct packed {
    logic       eol;
    logic [7:0] ch;
    logic [1:0] chk;
    token_t     want;
  } byte_item_t;

  localparam int unsigned N_DIRECTED = 26;
  localparam probe_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b1, 8'hA5, CHK_NONE,  KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, 8'hFF, CHK_NONE,  KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, 8'h80, CHK_NONE,  KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "(",   CHK_ONE,   KIND_LPAREN, 12'd2,  13'd1},
    '{1'b0, "i",   CHK_NONE,  KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "f",   CHK_NONE,  KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, " ",   CHK_ONE,   KIND_IF,     12'd3,  13'd2},
    '{1'b0, " ",   CHK_NONE,  KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "9",   CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "x",   CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, 8'h00, CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "|",   CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "|",   CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "]",   CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "0",   CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "7",   CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b1, 8'h5A, CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "&",   CHK_NONE,  KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "&",   CHK_NONE,  KIND_NUMBER, 12'd0,  13'd0},
    '{1'b1, 8'h00, CHK_ONE,   KIND_ANDAND, 12'd0,  13'd2},
    '{1'b0, " ",   CHK_NONE,  KIND_NUMBER, 12'd0,  13'd0},
    '{1'b1, 8'hFF, CHK_ONE,   KIND_IDENT,  12'd0,  13'd1},
    '{1'b0, "\"",  CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, "~",   CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b0, 8'h7F, CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0},
    '{1'b1, 8'h3C, CHK_MODEL, KIND_NUMBER, 12'd0,  13'd0}
  };

  string lexicon [N_WORDS] = '{
    "+", "-", "*", "/", "%", "=", "==", "(", ")", "[", "]", "{", "}",
    "||", "&&", "!", "|", "&", "~", "^", ":", ".", ";", ",",
    "return", "if", "else", "for", "while", "def", "break", "continue",
    "func", "read", "print", "var"
  };
  string punct = "+-*/=!~><|^%.,'\";:()[]{}";

  logic clk_i;
  logic rst_ni;

  ltok_req_if req_if ();
  ltok_tok_if tok_if ();

  line_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .tok_o  (tok_if)
  );

  // Tokenizer model state.
  mode_e             run_mode;
  logic              at_head;
  int unsigned       line_pos;
  int unsigned       txt_start;
  logic [7:0]        txt_head [WORD_CHARS];
  int unsigned       txt_len;
  logic              only_digits;
  logic [VALUE_W:0]  num_acc;
  token_t            fresh [$];

  byte_item_t  stim [$];
  token_t      expected_tokens [$];
  logic [7:0]  line_chars [$];
  byte_item_t  taken_item;
  int unsigned send_idx;
  int unsigned mismatches;
  int unsigned cycles;
  logic        req_fire;
  logic        calm;

  function automatic cls_e char_class(logic [7:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CL_LETTER;
    if (c >= "0" && c <= "9") return CL_DIGIT;
    case (c)
      "(", ")", "[", "]", "{", "}": return CL_BRACKET;
      " ": return CL_SPACE;
      "+", "-", "*", "/", "=", "!", "~", ">", "<", "|", "^", "%", ".", ",", "'",
      "\"", ";", ":": return CL_OPER;
      default: return CL_OTHER;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] lexicon_code(logic [7:0] hd [WORD_CHARS],
                                                     int unsigned len);
    logic same;
    for (int w = 0; w < N_WORDS; w++) begin
      if (lexicon[w].len() == len) begin
        same = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (lexicon[w][k] != hd[k]) same = 1'b0;
        end
        if (same) return KIND_WORD_BASE + KIND_W'(w);
      end
    end
    return KIND_NUMBER;
  endfunction

  function automatic void text_clear();
    txt_len     = 0;
    only_digits = 1'b1;
    num_acc     = '0;
  endfunction

  function automatic void line_restart();
    run_mode  = MODE_NONE;
    at_head   = 1'b1;
    line_pos  = 0;
    txt_start = 0;
    for (int k = 0; k < WORD_CHARS; k++) txt_head[k] = '0;
    text_clear();
  endfunction

  function automatic void text_push(logic [7:0] c, int unsigned pos);
    logic [VALUE_W:0] digit;
    if (txt_len == 0) txt_start = pos;
    if (txt_len < WORD_CHARS) txt_head[txt_len] = c;
    txt_len++;
    if (c >= "0" && c <= "9") begin
      digit = (VALUE_W + 1)'(c - "0");
      // The value sticks at its maximum once another digit would overflow it.
      if (num_acc > (NUM_MAX - digit) / 10) num_acc = NUM_MAX;
      else num_acc = num_acc * 10 + digit;
    end else begin
      only_digits = 1'b0;
    end
  endfunction

  function automatic void text_emit();
    token_t t;
    t = '0;
    if (txt_len <= WORD_CHARS) t.kind = lexicon_code(txt_head, txt_len);
    if (t.kind == KIND_NUMBER) begin
      if (only_digits) t.value = num_acc[VALUE_W-1:0];
      else t.kind = KIND_IDENT;
    end
    t.start  = START_W'(txt_start);
    t.length = LENGTH_W'(txt_len);
    fresh.insert(fresh.size(), t);
  endfunction

  function automatic void tokenize_byte(logic eol, logic [7:0] c);
    cls_e        cl;
    int unsigned pos;
    logic        again;
    logic        brk;
    token_t      t;
    logic [7:0]  one [WORD_CHARS];
    fresh.delete();
    pos = line_pos;
    if (eol) begin
      if (txt_len > 0) text_emit();
      line_restart();
    end else if (pos < LINE_LIMIT) begin
      cl = char_class(c);
      if (at_head && cl == CL_OTHER) begin
        text_push(c, pos);
      end else begin
        at_head = 1'b0;
        // A byte that breaks the open run is handled again with no run open.
        do begin
          again = 1'b0;
          if (cl == CL_SPACE) begin
            if (txt_len > 0) begin
              text_emit();
              text_clear();
              run_mode = MODE_NONE;
            end else begin
              text_push(c, pos);
            end
          end else if (run_mode == MODE_NONE) begin
            text_clear();
            case (cl)
              CL_LETTER: begin
                run_mode = MODE_LETTER;
                text_push(c, pos);
              end
              CL_DIGIT: begin
                run_mode = MODE_DIGIT;
                text_push(c, pos);
              end
              CL_OPER: begin
                run_mode = MODE_OPER;
                text_push(c, pos);
              end
              CL_BRACKET: begin
                for (int k = 0; k < WORD_CHARS; k++) one[k] = '0;
                one[0]   = c;
                t        = '0;
                t.kind   = lexicon_code(one, 1);
                t.start  = START_W'(pos);
                t.length = LENGTH_W'(1);
                fresh.insert(fresh.size(), t);
              end
              default: text_push(c, pos);
            endcase
          end else begin
            case (run_mode)
              MODE_LETTER: brk = (cl == CL_OPER || cl == CL_BRACKET);
              MODE_DIGIT:  brk = (cl != CL_DIGIT);
              default:     brk = (cl != CL_OPER);
            endcase
            if (brk) begin
              text_emit();
              text_clear();
              run_mode = MODE_NONE;
              again    = 1'b1;
            end else begin
              text_push(c, pos);
            end
          end
        end while (again);
      end
      line_pos = pos + 1;
    end
    if (fresh.size() > 0) begin
      t      = fresh.pop_back();
      t.last = 1'b1;
      fresh.insert(fresh.size(), t);
    end
  endfunction

  function automatic void put_char(logic [7:0] c);
    byte_item_t it;
    it     = '0;
    it.ch  = c;
    it.chk = CHK_MODEL;
    stim.insert(stim.size(), it);
  endfunction

  function automatic void put_eol();
    byte_item_t it;
    it     = '0;
    it.eol = 1'b1;
    it.ch  = 8'($urandom_range(0, 255));
    it.chk = CHK_MODEL;
    stim.insert(stim.size(), it);
  endfunction

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(128, 255));
      1:       return 8'($urandom_range(0, 31));
      2:       return "&";
      default: return "#";
    endcase
  endfunction

  function automatic logic [7:0] letter();
    if ($urandom_range(0, 1)) return 8'($urandom_range(97, 122));
    return 8'($urandom_range(65, 90));
  endfunction

  // Builds one line of plausible source text with some noise mixed in.
  function automatic void compose_line(int unsigned min_len);
    int unsigned pieces;
    int unsigned pick;
    int unsigned n;
    string       w;
    line_chars.delete();
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 2)) line_chars.insert(line_chars.size(), odd_byte());
    end
    pieces = $urandom_range(2, 12);
    while (pieces > 0 || line_chars.size() < min_len) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        w = lexicon[$urandom_range(0, N_WORDS - 1)];
        for (int k = 0; k < w.len(); k++) line_chars.insert(line_chars.size(), w[k]);
      end else if (pick < 45) begin
        n = $urandom_range(1, 9);
        repeat (n) begin
          case ($urandom_range(0, 11))
            0, 1:    line_chars.insert(line_chars.size(), 8'($urandom_range(48, 57)));
            2:       line_chars.insert(line_chars.size(), odd_byte());
            default: line_chars.insert(line_chars.size(), letter());
          endcase
        end
      end else if (pick < 63) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
        repeat (n) line_chars.insert(line_chars.size(), 8'($urandom_range(48, 57)));
      end else if (pick < 75) begin
        line_chars.insert(line_chars.size(), punct[$urandom_range(0, punct.len() - 1)]);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 2)) line_chars.insert(line_chars.size(), " ");
      end else begin
        line_chars.insert(line_chars.size(), 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1)) line_chars.insert(line_chars.size(), " ");
      if (pieces > 0) pieces--;
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("line_tokenizer: mismatch");
      $finish;
    end
  end

  // Checks each token transaction, then models each accepted byte transaction.
  always @(posedge clk_i) begin
    if (tok_if.valid && tok_if.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("token with none expected: kind %0d start %0d length %0d",
               tok_if.token_kind, tok_if.token_start, tok_if.token_length);
        mismatches++;
      end else begin
        check_field("token_kind", 64'(expected_tokens[0].kind), 64'(tok_if.token_kind));
        check_field("number_value", 64'(expected_tokens[0].value),
                    64'(tok_if.number_value));
        check_field("token_start", 64'(expected_tokens[0].start), 64'(tok_if.token_start));
        check_field("token_length", 64'(expected_tokens[0].length),
                    64'(tok_if.token_length));
        check_field("last", 64'(expected_tokens[0].last), 64'(tok_if.last));
        void'(expected_tokens.pop_front());
      end
    end
    req_fire = rst_ni && req_if.valid && req_if.ready;
    if (req_fire) begin
      taken_item = stim[send_idx];
      tokenize_byte(taken_item.eol, taken_item.ch);
      case (taken_item.chk)
        CHK_MODEL: foreach (fresh[k]) expected_tokens.insert(expected_tokens.size(), fresh[k]);
        CHK_ONE:   expected_tokens.insert(expected_tokens.size(), taken_item.want);
        default:   ;
      endcase
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid = 1'b0;
      tok_if.ready = 1'b0;
    end else begin
      calm = (send_idx >= CALM_FROM && send_idx < CALM_TO);
      if (!(req_if.valid && !req_fire)) begin
        if (req_fire) send_idx++;
        if (send_idx < stim.size() && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          req_if.req_type = stim[send_idx].eol;
          req_if.ch       = stim[send_idx].ch;
          req_if.valid    = 1'b1;
        end else begin
          req_if.valid = 1'b0;
        end
      end
      tok_if.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    byte_item_t it;
    req_if.valid    = 1'b0;
    req_if.req_type = 1'b0;
    req_if.ch       = '0;
    tok_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    req_fire        = 1'b0;
    send_idx        = 0;
    mismatches      = 0;
    cycles          = 0;
    line_restart();

    foreach (DIRECTED[r]) begin
      it             = '0;
      it.eol         = DIRECTED[r].eol;
      it.ch          = DIRECTED[r].ch;
      it.chk         = DIRECTED[r].chk;
      it.want.kind   = DIRECTED[r].kind;
      it.want.start  = DIRECTED[r].start;
      it.want.length = DIRECTED[r].length;
      it.want.last   = 1'b1;
      stim.insert(stim.size(), it);
    end

    while (stim.size() < N_DIRECTED + RANDOM_ITEMS) begin
      compose_line(0);
      foreach (line_chars[k]) put_char(line_chars[k]);
      put_eol();
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (send_idx == stim.size());
    wait (expected_tokens.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("line_tokenizer: match");
    end else begin
      $display("line_tokenizer: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
design/ltok_pkg.sv
design/ltok_ifs.sv
design/ltok_front.sv
design/ltok_queue.sv
design/ltok_back.sv
design/line_tokenizer.sv
design/ltok_checker.sv
verif/line_tokenizer_tb.sv
